// ===== rtl/r4bm_pkg.sv =====
// ----------------------------------------------------------------------------
// r4bm_pkg: shared types and helpers for the radix-4 Booth multiplier
// Widths derived from the operand width, Booth select codes and recoding.
// ----------------------------------------------------------------------------
`default_nettype none

package r4bm_pkg;

	// Field widths of the ports
	localparam int unsigned FIELD_W   = 16;
	localparam int unsigned PRODUCT_W = 32;

	// Internal operand width (bits of a port above it are ignored)
	localparam int unsigned OPERAND_WIDTH = 16;
	localparam int unsigned ACC_W         = 2 * OPERAND_WIDTH;
	localparam int unsigned NUM_GROUPS    = OPERAND_WIDTH / 2 + 1;
	localparam int unsigned EXT_W         = 2 * NUM_GROUPS + 1;

	// Second stage adds partial products in triples
	localparam int unsigned TRIPLE    = 3;
	localparam int unsigned NUM_SUMS  = (NUM_GROUPS + TRIPLE - 1) / TRIPLE;

	typedef logic [OPERAND_WIDTH-1:0] operand_t;
	typedef logic [ACC_W-1:0]         acc_t;
	typedef logic [EXT_W-1:0]         ext_t;
	typedef logic [2:0]               group_t;

	// Partial product selected by one Booth group
	typedef enum logic [2:0] {
		BS_ZERO,
		BS_POS1,
		BS_POS2,
		BS_NEG1,
		BS_NEG2
	} booth_sel_t;

	// Booth group codes, bits b[2i+1] b[2i] b[2i-1]
	localparam group_t GC_000 = 3'b000;
	localparam group_t GC_001 = 3'b001;
	localparam group_t GC_010 = 3'b010;
	localparam group_t GC_011 = 3'b011;
	localparam group_t GC_100 = 3'b100;
	localparam group_t GC_101 = 3'b101;
	localparam group_t GC_110 = 3'b110;
	localparam group_t GC_111 = 3'b111;

	function automatic booth_sel_t booth_decode(input group_t code);
		booth_sel_t sel;
		unique case (code)
			GC_001, GC_010: sel = BS_POS1;
			GC_011:         sel = BS_POS2;
			GC_100:         sel = BS_NEG2;
			GC_101, GC_110: sel = BS_NEG1;
			GC_000, GC_111: sel = BS_ZERO;
			default:        sel = BS_ZERO;
		endcase
		return sel;
	endfunction

	// Two's-complement partial product, already weighted by 4^idx
	function automatic acc_t booth_pp(input operand_t a, input booth_sel_t sel,
			input int unsigned idx);
		acc_t base;
		acc_t pp;
		base = ACC_W'(a);
		unique case (sel)
			BS_POS1: pp = base;
			BS_POS2: pp = base << 1;
			BS_NEG1: pp = ~base + acc_t'(1);
			BS_NEG2: pp = ~(base << 1) + acc_t'(1);
			BS_ZERO: pp = '0;
			default: pp = '0;
		endcase
		return pp << (2 * idx);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/radix4_booth_multiplier_core.sv =====
// ----------------------------------------------------------------------------
// radix4_booth_multiplier_core: pipelined unsigned radix-4 Booth multiplier
// Booth recoding and partial products, triple adds, final add into product.
// ----------------------------------------------------------------------------
// Registers: pp_s1, sum_s2, then product_s3 driving the product output.
// Throughput: one operand pair per cycle while out_ready is high; each of the
//   three stages holds one item, moving on once the stage after it is free.
// Stall: out_ready low backs up stage by stage; in_ready drops only when all
//   three stages are full.
// Reset: arst_n clears the stage valid bits; data registers are not reset.
`default_nettype none

module radix4_booth_multiplier_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [r4bm_pkg::FIELD_W-1:0]     multiplicand,
	input  wire logic [r4bm_pkg::FIELD_W-1:0]     multiplier,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [r4bm_pkg::PRODUCT_W-1:0]        product
);
	import r4bm_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic ready_s1, ready_s2, ready_s3;

	operand_t a_in, b_in;
	ext_t     b_ext;
	acc_t     pp_d [NUM_GROUPS];
	acc_t     pp_s1 [NUM_GROUPS];
	acc_t     sum_d [NUM_SUMS];
	acc_t     sum_s2 [NUM_SUMS];
	acc_t     total_d;
	acc_t     product_s3;

	// Stage ready chain: a stage takes a new item when empty or draining
	assign ready_s3 = !v_s3 || out_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Stage 1: Booth recoding and partial product selection
	assign a_in  = operand_t'(multiplicand);
	assign b_in  = operand_t'(multiplier);
	assign b_ext = {(EXT_W-1)'(b_in), 1'b0};

	always_comb begin
		for (int unsigned i = 0; i < NUM_GROUPS; i++) begin
			pp_d[i] = booth_pp(a_in, booth_decode(b_ext[2*i +: 3]), i);
		end
	end

	// Stage 2: partial products added in triples
	always_comb begin
		for (int unsigned k = 0; k < NUM_SUMS; k++) begin
			sum_d[k] = '0;
			for (int unsigned j = 0; j < TRIPLE; j++) begin
				if (k * TRIPLE + j < NUM_GROUPS) begin
					sum_d[k] = sum_d[k] + pp_s1[k * TRIPLE + j];
				end
			end
		end
	end

	// Stage 3: final sum, wraps modulo 2^ACC_W
	always_comb begin
		total_d = '0;
		for (int unsigned k = 0; k < NUM_SUMS; k++) begin
			total_d = total_d + sum_s2[k];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Data registers, loaded only on a transfer into the stage
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			pp_s1 <= pp_d;
		end
		if (ready_s2 && v_s1) begin
			sum_s2 <= sum_d;
		end
		if (ready_s3 && v_s2) begin
			product_s3 <= total_d;
		end
	end

	assign out_valid = v_s3;
	assign product   = PRODUCT_W'(product_s3);

`ifndef SYNTHESIS
	// Input stalls only with the whole pipeline full and the output blocked
	a_full_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && !out_ready))
		else $error("in_ready low while pipeline can advance");

	// An accepted input lands in stage 1
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted item missing from stage 1");

	// A stage-2 item moving on reaches the output
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && ready_s3) |=> out_valid)
		else $error("stage 2 item lost before output");

	// A held output stays valid with the same product
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !out_ready) |=> (v_s3 && $stable(product_s3)))
		else $error("stalled product changed");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for radix4_booth_multiplier_core
// Drives operand pairs over a valid/ready channel with random idling on both
// sides, predicts each product by Booth recoding of the multiplier, and
// compares every output transfer against the oldest predicted product.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import r4bm_pkg::*;

	typedef struct packed {
		logic [FIELD_W-1:0] mcand;
		logic [FIELD_W-1:0] mplier;
	} operand_pair_t;

	localparam int NUM_RANDOM  = 1300;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 8;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [FIELD_W-1:0]   multiplicand = '0;
	logic [FIELD_W-1:0]   multiplier   = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [PRODUCT_W-1:0] product;

	operand_pair_t        pending_pairs[$];
	operand_pair_t        next_pair;
	logic [PRODUCT_W-1:0] expected_products[$];
	logic [PRODUCT_W-1:0] want_product;
	int                   n_sent   = 0;
	int                   n_total  = 0;
	int                   n_errors = 0;

	radix4_booth_multiplier_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.multiplicand (multiplicand),
		.multiplier   (multiplier),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.product      (product)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Booth recoded product: sum of signed digit multiples of A weighted by 4^i
	function automatic logic [PRODUCT_W-1:0] booth_product(input logic [FIELD_W-1:0] a_in,
			input logic [FIELD_W-1:0] b_in);
		logic [63:0] opmask;
		logic [63:0] a;
		logic [63:0] ext;
		logic [63:0] pp;
		logic [63:0] sum;
		group_t      code;
		int          i;
		opmask = (64'd1 << OPERAND_WIDTH) - 64'd1;
		a      = 64'(a_in) & opmask;
		ext    = (64'(b_in) & opmask) << 1;
		sum    = '0;
		for (i = 0; i < NUM_GROUPS; i++) begin
			code = ext[2*i +: 3];
			case (code)
				GC_001, GC_010: pp = a;
				GC_011:         pp = a << 1;
				GC_100:         pp = ~(a << 1) + 64'd1;
				GC_101, GC_110: pp = ~a + 64'd1;
				default:        pp = '0;
			endcase
			sum += pp << (2 * i);
		end
		sum &= (64'd1 << ACC_W) - 64'd1;
		return sum[PRODUCT_W-1:0];
	endfunction

	// Operand with a bias toward corners and long runs of ones
	function automatic logic [FIELD_W-1:0] random_operand();
		logic [FIELD_W:0] hi_mask;
		logic [FIELD_W:0] lo_mask;
		int               lo;
		int               hi;
		logic [FIELD_W-1:0] val;
		lo = $urandom_range(FIELD_W - 1);
		hi = $urandom_range(FIELD_W - 1, lo);
		hi_mask = (17'd1 << (hi + 1)) - 17'd1;
		lo_mask = (17'd1 << lo) - 17'd1;
		case ($urandom_range(9))
			0:       val = '0;
			1:       val = '1;
			2:       val = FIELD_W'(1) << lo;
			3:       val = ~(FIELD_W'(1) << lo);
			4:       val = FIELD_W'(hi_mask ^ lo_mask);
			default: val = FIELD_W'($urandom);
		endcase
		return val;
	endfunction

	// Idle percentages per phase: receiver-heavy, sender-heavy, then none
	function automatic int sender_idle_pct();
		if (n_sent < n_total / 3)
			return 23;
		else if (n_sent < 2 * n_total / 3)
			return 48;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (n_sent < n_total / 3)
			return 48;
		else if (n_sent < 2 * n_total / 3)
			return 23;
		return 0;
	endfunction

	task automatic note_failure(input string msg);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic add_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
		operand_pair_t p;
		p.mcand  = a;
		p.mplier = b;
		pending_pairs.push_back(p);
	endtask

	// Input driver: predicts on each input transfer, then loads the next pair
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_products.push_back(booth_product(multiplicand, multiplier));
				n_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
					next_pair = pending_pairs.pop_front();
					multiplicand <= next_pair.mcand;
					multiplier   <= next_pair.mplier;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each output transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_products.size() == 0) begin
					note_failure($sformatf("unexpected product %08h", product));
				end else begin
					want_product = expected_products.pop_front();
					if (product !== want_product)
						note_failure($sformatf("product expected %08h actual %08h",
							want_product, product));
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_idle_pct());
		end
	end

	// Stimulus, reset and end of run
	initial begin
		// corners and every Booth digit, high groups included
		add_pair(16'h0000, 16'h0000);
		add_pair(16'hFFFF, 16'hFFFF);
		add_pair(16'hFFFF, 16'h0000);
		add_pair(16'h0000, 16'hFFFF);
		add_pair(16'h0001, 16'h0001);
		add_pair(16'hFFFF, 16'h0001);
		add_pair(16'h0001, 16'hFFFF);
		add_pair(16'h8000, 16'h8000);
		add_pair(16'hFFFF, 16'h5555);
		add_pair(16'hFFFF, 16'hAAAA);
		add_pair(16'hFFFF, 16'h3333);
		add_pair(16'hABCD, 16'hCCCC);
		add_pair(16'h1234, 16'h6666);
		add_pair(16'hFFFF, 16'h8000);
		add_pair(16'hFFFF, 16'h7FFF);
		add_pair(16'h7FFF, 16'hFFFF);
		add_pair(16'h8001, 16'h9999);
		add_pair(16'hFFFF, 16'hEEEE);
		add_pair(16'hFEDC, 16'h1111);
		add_pair(16'h0001, 16'h0002);
		repeat (NUM_RANDOM)
			add_pair(random_operand(), random_operand());
		n_total = pending_pairs.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_pairs.size() == 0 && !in_valid);
		wait (expected_products.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_products.size() != 0)
			note_failure($sformatf("%0d products never arrived", expected_products.size()));
		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/r4bm_pkg.sv
rtl/radix4_booth_multiplier_core.sv
dv/tb.sv
